/* rtl/core/mhas_pkg.sv */
// Shared types and constants for the multi-head attention score block.
`timescale 1ns / 1ps
package mhas_pkg;

  // Store geometry
  localparam int unsigned MaxHeads  = 32;
  localparam int unsigned MaxDim    = 128;
  localparam int unsigned QDepth    = MaxHeads * MaxDim;
  localparam int unsigned QAddrW    = $clog2(QDepth);
  localparam int unsigned HeadW     = $clog2(MaxHeads);
  localparam int unsigned DimCntW   = $clog2(MaxDim);

  // Field and register widths
  localparam int unsigned ValueW    = 16;
  localparam int unsigned ProdW     = 2 * ValueW;
  localparam int unsigned ScoreW    = 48;
  localparam int unsigned PosW      = 16;
  localparam int unsigned SeqLenW   = 16;
  localparam int unsigned HeadCntW  = 6;
  localparam int unsigned HeadDimW  = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeqLen   = 2'd0,
    CfgHeadCnt  = 2'd1,
    CfgHeadDim  = 2'd2,
    CfgUnused   = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CmdLoadQuery = 1'b0,
    CmdKey       = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     command;
    logic signed [ValueW-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic [HeadW-1:0]         head_index;
    logic [PosW-1:0]          position_index;
    logic                     last_score;
  } out_rsp_t;

  // Bookkeeping that travels with a key element down the pipeline
  typedef struct packed {
    logic             last_dim;
    logic             last_score;
    logic [HeadW-1:0] head;
    logic [PosW-1:0]  pos;
  } key_meta_t;

endpackage

/* rtl/core/multi_head_attention_score.sv */
// Top level of the multi-head attention score (Q dot K) block.
// A key element that closes a vector passes stage 1, stage 2 and the output register before its score shows.
// Throughput: one request per cycle while the input is not stalled; the saturating accumulate loop sets it.
// Stall on the input follows a held, untaken result in the output register.
// Reset: counters, accumulator and pipeline valids clear, registers take their defaults;
// the query store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module multi_head_attention_score (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mhas_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mhas_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mhas_pkg::in_req_t            in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mhas_pkg::out_rsp_t           out_rsp_o
);
  import mhas_pkg::*;

  // Configuration registers
  logic [SeqLenW-1:0]  seq_len_q;
  logic [HeadCntW-1:0] head_cnt_cfg_q;
  logic [HeadDimW-1:0] head_dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q      <= SeqLenW'(1);
      head_cnt_cfg_q <= HeadCntW'(1);
      head_dim_q     <= HeadDimW'(MaxDim);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSeqLen:  seq_len_q      <= cfg_wdata_i[SeqLenW-1:0];
        CfgHeadCnt: head_cnt_cfg_q <= cfg_wdata_i[HeadCntW-1:0];
        CfgHeadDim: head_dim_q     <= cfg_wdata_i[HeadDimW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to their usable ranges
  logic [SeqLenW-1:0]  seq_eff;
  logic [HeadCntW-1:0] heads_eff;
  logic [HeadDimW-1:0] dim_eff;

  always_comb begin
    seq_eff = (seq_len_q == '0) ? SeqLenW'(1) : seq_len_q;
    if (head_cnt_cfg_q == '0)                        heads_eff = HeadCntW'(1);
    else if (head_cnt_cfg_q > HeadCntW'(MaxHeads))   heads_eff = HeadCntW'(MaxHeads);
    else                                             heads_eff = head_cnt_cfg_q;
    if (head_dim_q == '0)                            dim_eff = HeadDimW'(1);
    else if (head_dim_q > HeadDimW'(MaxDim))         dim_eff = HeadDimW'(MaxDim);
    else                                             dim_eff = head_dim_q;
  end

  // Pipeline advance: everything moves unless a result sits untaken
  logic advance;
  logic in_acc;
  logic is_key;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_acc     = in_valid_i && advance;
  assign is_key     = (cmd_e'(in_req_i.command) == CmdKey);

  // Counters
  logic [QAddrW-1:0]  load_idx_q, load_idx_d;
  logic [HeadW-1:0]   head_q, head_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [DimCntW-1:0] dim_q, dim_d;

  logic [HeadCntW+HeadDimW-1:0] load_limit;
  logic                         load_wrap;
  logic                         last_dim, last_pos, last_head;
  logic [HeadW+HeadDimW-1:0]    head_base;
  logic [HeadW+HeadDimW-1:0]    rd_addr_full;
  logic [QAddrW-1:0]            rd_addr;
  key_meta_t                    meta_in;

  always_comb begin
    load_limit   = heads_eff * dim_eff;
    load_wrap    = ((HeadCntW+HeadDimW)'(load_idx_q) + 1'b1) >= load_limit;
    last_dim     = ({1'b0, dim_q} + HeadDimW'(1)) >= dim_eff;
    last_pos     = ({1'b0, pos_q} + (PosW+1)'(1)) >= {1'b0, seq_eff};
    last_head    = ({1'b0, head_q} + HeadCntW'(1)) >= heads_eff;
    head_base    = head_q * dim_eff;
    rd_addr_full = head_base + (HeadW+HeadDimW)'(dim_q);
    rd_addr      = rd_addr_full[QAddrW-1:0];

    meta_in.last_dim   = last_dim;
    meta_in.last_score = last_pos && last_head;
    meta_in.head       = head_q;
    meta_in.pos        = pos_q;

    load_idx_d = load_idx_q;
    head_d     = head_q;
    pos_d      = pos_q;
    dim_d      = dim_q;
    if (in_acc && !is_key) begin
      load_idx_d = load_wrap ? '0 : load_idx_q + 1'b1;
    end else if (in_acc && is_key) begin
      if (!last_dim) begin
        dim_d = dim_q + 1'b1;
      end else begin
        dim_d = '0;
        if (!last_pos) begin
          pos_d = pos_q + 1'b1;
        end else begin
          pos_d  = '0;
          head_d = last_head ? '0 : head_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
      head_q     <= '0;
      pos_q      <= '0;
      dim_q      <= '0;
    end else begin
      load_idx_q <= load_idx_d;
      head_q     <= head_d;
      pos_q      <= pos_d;
      dim_q      <= dim_d;
    end
  end

  // Query store: write on a query load, registered read on a key element
  logic [ValueW-1:0] qmem [QDepth];
  logic [ValueW-1:0] q_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_key) begin
      qmem[load_idx_q] <= in_req_i.value;
    end
    if (in_acc && is_key) begin
      q_rd_q <= qmem[rd_addr];
    end
  end

  // Stage 1: key value and bookkeeping alongside the store read
  logic                     s1_valid_q;
  logic signed [ValueW-1:0] s1_value_q;
  key_meta_t                s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_acc && is_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_key) begin
      s1_value_q <= in_req_i.value;
      s1_meta_q  <= meta_in;
    end
  end

  // Stage 2: exact Q2.30 product
  logic                    s2_valid_q;
  logic signed [ProdW-1:0] s2_prod_q;
  key_meta_t               s2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      s2_prod_q <= $signed(q_rd_q) * s1_value_q;
      s2_meta_q <= s1_meta_q;
    end
  end

  // Stage 3: saturating accumulate, emit on the last dimension
  logic signed [ScoreW-1:0] acc_q, acc_d;
  logic signed [ScoreW:0]   sum_wide;
  logic signed [ScoreW-1:0] sum_sat;
  logic                     acc_step;
  logic                     emit;

  always_comb begin
    acc_step = advance && s2_valid_q;
    emit     = acc_step && s2_meta_q.last_dim;
    sum_wide = {acc_q[ScoreW-1], acc_q} + (ScoreW+1)'(s2_prod_q);
    if (sum_wide[ScoreW] != sum_wide[ScoreW-1]) begin
      sum_sat = sum_wide[ScoreW] ? {1'b1, {(ScoreW-1){1'b0}}} : {1'b0, {(ScoreW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[ScoreW-1:0];
    end
    acc_d = acc_q;
    if (acc_step) begin
      acc_d = s2_meta_q.last_dim ? '0 : sum_sat;
    end
  end

  logic     out_valid_q;
  out_rsp_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (advance) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.score          <= sum_sat;
      out_q.head_index     <= s2_meta_q.head;
      out_q.position_index <= s2_meta_q.pos;
      out_q.last_score     <= s2_meta_q.last_score;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  // A result appears only after a key element that closes its vector
  a_emit_only_last_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !(s2_valid_q && s2_meta_q.last_dim) |=> !out_valid_o)
    else $error("result without a closing key element");

  // Accumulator restarts after every emitted score
  a_acc_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> acc_q == '0)
    else $error("accumulator not cleared after a score");

  // Dimension counter returns to zero when a vector closes
  a_dim_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_key && last_dim |=> dim_q == '0)
    else $error("dimension counter did not wrap");
`endif

endmodule
